// ----- design/roida_pkg.sv -----
// roida_pkg: shared types and constants for the random order id allocator
// no dependencies; used by roida_tbl, roida_rem and random_order_id_allocator_top

package roida_pkg;

	localparam int NUM_IDS = 64;
	localparam int ID_W    = $clog2(NUM_IDS);
	localparam int CNT_W   = $clog2(NUM_IDS + 1);
	localparam int RND_W   = 16;
	localparam int STEP_W  = $clog2(RND_W + 1);

	typedef enum logic [1:0] {
		MODE_EXTRACT = 2'd0,
		MODE_RECYCLE = 2'd1,
		MODE_RESERVE = 2'd2,
		MODE_UNUSED  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_HELD  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EX_RD,
		ST_DIV,
		ST_RC_RD,
		ST_RC_PUSH,
		ST_RS_RD,
		ST_OUT
	} state_t;

	typedef struct packed {
		mode_t             mode;
		logic [ID_W-1:0]   id_in;
		logic [RND_W-1:0]  rand_value;
	} req_item_t;

	typedef struct packed {
		logic [ID_W-1:0]   id_out;
		status_t           status;
		logic [CNT_W-1:0]  free_count;
	} rsp_item_t;

	// one write port of an id table
	typedef struct packed {
		logic             en;
		logic [ID_W-1:0]  addr;
		logic [ID_W-1:0]  data;
	} tbl_wr_t;

endpackage

// ----- design/random_order_id_allocator_top.sv -----
// random_order_id_allocator_top: id pool with free stack, reverse slot map and held marks
// depends on roida_pkg, roida_tbl, roida_rem

// One request is taken at a time: req_ready is high only while the block is idle,
// and the result waits in an output register until rsp_ready takes it. An error,
// the unused mode or a recycle into an empty pool goes from decode straight to the
// output state; extract and reserve pass through a table read state first. Recycle
// into a nonempty pool waits for the bit-serial remainder unit, which works out
// rand_value mod free count one bit per cycle (16 steps), followed by a stack read
// and two table write steps. Both tables come out of reset in identity order through
// per-entry valid bits, so no clearing pass is needed.

module random_order_id_allocator_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  roida_pkg::req_item_t   req,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output roida_pkg::rsp_item_t   rsp
);
	import roida_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  ft_q, ft_d;
	logic [NUM_IDS-1:0] held_q;
	logic              held_set, held_clr;
	logic [ID_W-1:0]   held_idx;
	req_item_t         req_q;
	rsp_item_t         rsp_q, rsp_d;
	logic              rsp_load;
	logic [ID_W-1:0]   slot_q, slot_d;
	logic [ID_W-1:0]   moved_q, moved_d;

	tbl_wr_t           fs_wr, sm_wr;
	logic              fs_re, sm_re;
	logic [ID_W-1:0]   fs_raddr, sm_raddr;
	logic [ID_W-1:0]   fs_rd, sm_rd;

	logic              div_start, div_done;
	logic [CNT_W-1:0]  div_rem;

	logic [CNT_W-1:0]  id_ext;
	logic [CNT_W-1:0]  ft_dec;
	logic [ID_W-1:0]   top_idx;
	logic              accept;

	roida_tbl u_free_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fs_wr),
		.re     (fs_re),
		.raddr  (fs_raddr),
		.rdata  (fs_rd)
	);

	roida_tbl u_slot_map (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (sm_wr),
		.re     (sm_re),
		.raddr  (sm_raddr),
		.rdata  (sm_rd)
	);

	roida_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req_q.rand_value),
		.divisor  (ft_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = (state_q == ST_OUT);
	assign rsp       = rsp_q;
	assign accept    = req_valid && req_ready;

	assign id_ext  = CNT_W'(req_q.id_in);
	assign ft_dec  = ft_q - CNT_W'(1);
	assign top_idx = ft_dec[ID_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ft_q    <= CNT_W'(NUM_IDS);
			held_q  <= '0;
		end else begin
			state_q <= state_d;
			ft_q    <= ft_d;
			if (held_set) begin
				held_q[held_idx] <= 1'b1;
			end
			if (held_clr) begin
				held_q[held_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
		slot_q  <= slot_d;
		moved_q <= moved_d;
	end

	always_comb begin
		state_d   = state_q;
		ft_d      = ft_q;
		held_set  = 1'b0;
		held_clr  = 1'b0;
		held_idx  = req_q.id_in;
		slot_d    = slot_q;
		moved_d   = moved_q;
		fs_wr     = '0;
		sm_wr     = '0;
		fs_re     = 1'b0;
		sm_re     = 1'b0;
		fs_raddr  = top_idx;
		sm_raddr  = req_q.id_in;
		div_start = 1'b0;
		rsp_load  = 1'b0;
		rsp_d.id_out     = req_q.id_in;
		rsp_d.status     = STAT_OK;
		rsp_d.free_count = ft_d;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (req_q.mode)
					MODE_EXTRACT: begin
						if (ft_q == '0) begin
							rsp_d.id_out = '0;
							rsp_d.status = STAT_EMPTY;
							rsp_load     = 1'b1;
							state_d      = ST_OUT;
						end else begin
							fs_re   = 1'b1;
							state_d = ST_EX_RD;
						end
					end
					MODE_RECYCLE: begin
						priority if (id_ext >= CNT_W'(NUM_IDS)) begin
							rsp_d.status = STAT_RANGE;
							rsp_load     = 1'b1;
							state_d      = ST_OUT;
						end else if (!held_q[req_q.id_in]) begin
							rsp_d.status = STAT_HELD;
							rsp_load     = 1'b1;
							state_d      = ST_OUT;
						end else if (ft_q == '0) begin
							// empty pool: push straight into slot zero
							held_clr      = 1'b1;
							fs_wr.en      = 1'b1;
							fs_wr.addr    = '0;
							fs_wr.data    = req_q.id_in;
							sm_wr.en      = 1'b1;
							sm_wr.addr    = req_q.id_in;
							sm_wr.data    = '0;
							ft_d          = CNT_W'(1);
							rsp_d.free_count = CNT_W'(1);
							rsp_load      = 1'b1;
							state_d       = ST_OUT;
						end else begin
							div_start = 1'b1;
							state_d   = ST_DIV;
						end
					end
					MODE_RESERVE: begin
						priority if (id_ext >= CNT_W'(NUM_IDS)) begin
							rsp_d.status = STAT_RANGE;
							rsp_load     = 1'b1;
							state_d      = ST_OUT;
						end else if (held_q[req_q.id_in] || ft_q == '0) begin
							rsp_d.status = STAT_HELD;
							rsp_load     = 1'b1;
							state_d      = ST_OUT;
						end else begin
							// slot of the named id and the top entry, read together
							fs_re   = 1'b1;
							sm_re   = 1'b1;
							state_d = ST_RS_RD;
						end
					end
					MODE_UNUSED: begin
						rsp_load = 1'b1;
						state_d  = ST_OUT;
					end
				endcase
			end
			ST_EX_RD: begin
				held_set         = 1'b1;
				held_idx         = fs_rd;
				ft_d             = ft_dec;
				rsp_d.id_out     = fs_rd;
				rsp_d.free_count = ft_dec;
				rsp_load         = 1'b1;
				state_d          = ST_OUT;
			end
			ST_DIV: begin
				if (div_done) begin
					fs_re    = 1'b1;
					fs_raddr = div_rem[ID_W-1:0];
					slot_d   = div_rem[ID_W-1:0];
					state_d  = ST_RC_RD;
				end
			end
			ST_RC_RD: begin
				moved_d    = fs_rd;
				fs_wr.en   = 1'b1;
				fs_wr.addr = slot_q;
				fs_wr.data = req_q.id_in;
				sm_wr.en   = 1'b1;
				sm_wr.addr = req_q.id_in;
				sm_wr.data = slot_q;
				state_d    = ST_RC_PUSH;
			end
			ST_RC_PUSH: begin
				// displaced id goes on top of the stack
				held_clr   = 1'b1;
				fs_wr.en   = 1'b1;
				fs_wr.addr = ft_q[ID_W-1:0];
				fs_wr.data = moved_q;
				sm_wr.en   = 1'b1;
				sm_wr.addr = moved_q;
				sm_wr.data = ft_q[ID_W-1:0];
				ft_d       = ft_q + CNT_W'(1);
				rsp_d.free_count = ft_q + CNT_W'(1);
				rsp_load   = 1'b1;
				state_d    = ST_OUT;
			end
			ST_RS_RD: begin
				fs_wr.en   = 1'b1;
				fs_wr.addr = sm_rd;
				fs_wr.data = fs_rd;
				sm_wr.en   = 1'b1;
				sm_wr.addr = fs_rd;
				sm_wr.data = sm_rd;
				held_set   = 1'b1;
				ft_d       = ft_dec;
				rsp_d.free_count = ft_dec;
				rsp_load   = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_ft_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ft_q <= CNT_W'(NUM_IDS))
		else $error("free count above pool size");

	a_held_balance: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(held_q) + int'(ft_q)) == NUM_IDS)
		else $error("held marks and free count disagree");

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("request taken while a result is pending");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("remainder finished outside the divide step");

	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !rsp_valid)
		else $error("result shown in the cycle after an item was taken");
`endif

endmodule

// ----- design/roida_tbl.sv -----
// roida_tbl: NUM_IDS x ID_W table, one write and one registered read per cycle
// entries never written read back as their own index; depends on roida_pkg

module roida_tbl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  roida_pkg::tbl_wr_t      wr,
	input  logic                    re,
	input  logic [roida_pkg::ID_W-1:0] raddr,
	output logic [roida_pkg::ID_W-1:0] rdata
);
	import roida_pkg::*;

	logic [ID_W-1:0]    mem [NUM_IDS];
	logic [NUM_IDS-1:0] vld_q;
	logic [ID_W-1:0]    rdata_q;
	logic [ID_W-1:0]    raddr_q;
	logic               rvld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (re) begin
			rdata_q <= mem[raddr];
			raddr_q <= raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	// identity order until an entry is first written
	assign rdata = rvld_q ? rdata_q : raddr_q;

endmodule

// ----- design/roida_rem.sv -----
// roida_rem: bit-serial restoring remainder, one dividend bit per cycle
// depends on roida_pkg; divisor must be nonzero

module roida_rem (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [roida_pkg::RND_W-1:0] dividend,
	input  logic [roida_pkg::CNT_W-1:0] divisor,
	output logic                     done,
	output logic [roida_pkg::CNT_W-1:0] rem
);
	import roida_pkg::*;

	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [RND_W-1:0]  dvd_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic [CNT_W-1:0]  rem_nxt;

	assign trial   = {rem_q, dvd_q[RND_W-1]};
	assign diff    = trial - {1'b0, div_q};
	assign rem_nxt = (trial >= {1'b0, div_q}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= STEP_W'(RND_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= rem_nxt;
			dvd_q <= dvd_q << 1;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
